>>> rtl/acpd_pkg.sv
// Package for the AC phase-angle dimmer: register codes, reset values and the
// configuration struct shared by the register bank and the timing core.
// No dependencies.
`default_nettype none

package acpd_pkg;

  localparam int unsigned CounterWidthDefault = 16;

  // reset values of the configuration registers
  localparam logic [15:0] LockoutReset  = 16'd1125;
  localparam logic [15:0] MinDelayReset = 16'd330;
  localparam logic [7:0]  StepReset     = 8'd9;

  // dim level that fires the gate right at the crossing
  localparam logic [6:0]  FullLevel     = 7'd100;

  // step (8b) * (100 - level) (7b) + offset (16b) needs 17 bits
  localparam int unsigned DelayCalcWidth = 17;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_ENABLE    = 3'd0,
    REG_DIM_LEVEL = 3'd1,
    REG_LOCKOUT   = 3'd2,
    REG_MIN_DELAY = 3'd3,
    REG_STEP      = 3'd4
  } acpd_reg_e;

  typedef struct packed {
    logic        enable;
    logic [6:0]  dim_level;
    logic [15:0] lockout_ticks;
    logic [15:0] min_delay_ticks;
    logic [7:0]  delay_step_ticks;
  } acpd_cfg_t;

endpackage

`default_nettype wire

>>> rtl/acpd_cfg_regs.sv
// Configuration register bank of the dimmer.
// Depends on acpd_pkg (register codes, reset values, acpd_cfg_t).
`default_nettype none

module acpd_cfg_regs import acpd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     wr_en_i,
  input  wire logic [CfgIndexWidth-1:0] wr_index_i,
  input  wire logic [CfgDataWidth-1:0]  wr_data_i,
  output acpd_cfg_t                     cfg_o
);

  acpd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_ENABLE:    cfg_d.enable           = wr_data_i[0];
        REG_DIM_LEVEL: cfg_d.dim_level        = wr_data_i[6:0];
        REG_LOCKOUT:   cfg_d.lockout_ticks    = wr_data_i;
        REG_MIN_DELAY: cfg_d.min_delay_ticks  = wr_data_i;
        REG_STEP:      cfg_d.delay_step_ticks = wr_data_i[7:0];
        default:       cfg_d = cfg_q; // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable           <= 1'b0;
      cfg_q.dim_level        <= 7'd0;
      cfg_q.lockout_ticks    <= LockoutReset;
      cfg_q.min_delay_ticks  <= MinDelayReset;
      cfg_q.delay_step_ticks <= StepReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/acpd_core.sv
// Per-tick timing core: edge detect, lockout, firing delay and gate state.
// Depends on acpd_pkg (acpd_cfg_t, FullLevel, DelayCalcWidth).
`default_nettype none

module acpd_core import acpd_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,      // one tick processed this cycle
  input  wire logic      level_i,
  input  wire acpd_cfg_t cfg_i,
  output logic           triac_on_o,  // gate level after this tick
  output logic           crossing_o
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned LW = (CW > 16) ? CW : 16;
  localparam int unsigned SW = (CW > DelayCalcWidth) ? CW : DelayCalcWidth;

  logic          last_level_q, last_level_d;
  logic [CW-1:0] since_q, since_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] target_q, target_d;
  logic          armed_q, armed_d;
  logic          gate_q, gate_d;

  logic [CW-1:0] elapsed, count_inc, target_calc;
  logic [6:0]    level_gap;
  logic [14:0]   product;
  logic [SW-1:0] delay_wide;
  logic          accepted;

  assign elapsed   = (since_q == {CW{1'b1}}) ? since_q : since_q + CW'(1);
  assign count_inc = (count_q == {CW{1'b1}}) ? count_q : count_q + CW'(1);
  assign accepted  = level_i && !last_level_q && (LW'(elapsed) > LW'(cfg_i.lockout_ticks));

  // firing delay, clamped to the counter range
  assign level_gap   = FullLevel - cfg_i.dim_level;
  assign product     = 15'(cfg_i.delay_step_ticks) * 15'(level_gap);
  assign delay_wide  = SW'(DelayCalcWidth'(product) + DelayCalcWidth'(cfg_i.min_delay_ticks));
  assign target_calc = (delay_wide > SW'({CW{1'b1}})) ? {CW{1'b1}} : CW'(delay_wide);

  always_comb begin
    last_level_d = last_level_q;
    since_d      = since_q;
    count_d      = count_q;
    target_d     = target_q;
    armed_d      = armed_q;
    gate_d       = gate_q;
    if (step_i) begin
      last_level_d = level_i;
      if (accepted) begin
        since_d = '0;
        gate_d  = 1'b0;
        armed_d = 1'b0;
        if (cfg_i.enable && (cfg_i.dim_level != 7'd0)) begin
          if (cfg_i.dim_level >= FullLevel) begin
            gate_d = 1'b1;
          end else begin
            target_d = target_calc;
            count_d  = '0;
            armed_d  = 1'b1;
          end
        end
      end else begin
        since_d = elapsed;
        if (armed_q) begin
          count_d = count_inc;
          if (count_inc >= target_q) begin
            gate_d  = 1'b1;
            armed_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      since_q      <= '0;
      count_q      <= '0;
      target_q     <= '0;
      armed_q      <= 1'b0;
      gate_q       <= 1'b0;
    end else begin
      last_level_q <= last_level_d;
      since_q      <= since_d;
      count_q      <= count_d;
      target_q     <= target_d;
      armed_q      <= armed_d;
      gate_q       <= gate_d;
    end
  end

  assign triac_on_o = gate_d;
  assign crossing_o = step_i && accepted;

`ifndef SYNTHESIS
  // a pending delay always has the gate off
  a_armed_gate_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(armed_q && gate_q))
    else $error("delay armed while gate is on");

  // an accepted crossing restarts the elapsed counter
  a_crossing_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crossing_o |=> (since_q == '0))
    else $error("elapsed counter not cleared by crossing");

  // state only moves on a processed tick
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(since_q) && $stable(gate_q) && $stable(armed_q)))
    else $error("state changed without a tick");
`endif

endmodule

`default_nettype wire

>>> rtl/ac_phase_angle_dimmer_unit.sv
// Top level of the AC phase-angle dimmer: stream handshakes, input and result
// registers. Depends on acpd_pkg, acpd_cfg_regs and acpd_core.
//
//  channel   | dir | tdata / payload                      | handshake
//  ----------+-----+--------------------------------------+---------------------------
//  s_axis    | in  | [0] zero_cross_level, [7:1] zero     | s_axis_tvalid/tready
//  m_axis    | out | [0] triac_on, [1] crossing_accepted  | m_axis_tvalid/tready
//  cfg       | in  | cfg_index_i (reg 0..4), cfg_data_i   | cfg_valid_i/cfg_ready_o
//
// One item per clock sustained while m_axis_tready stays high; an item passes the
// input register, then the timing core feeding the result register. The core is
// a single pass: edge check, one 8x7 multiply-add for the delay, saturating counters.
// Reset (rst_ni, async low) clears the valid flags and the core state and loads
// the register defaults. A stalled result holds the pipe; the input side keeps
// taking an item while its register is empty. cfg is always ready.
`default_nettype none

module ac_phase_angle_dimmer_unit import acpd_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input items
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [7:0]               s_axis_tdata,   // [0] zero_cross_level
  // result items
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [0] triac_on, [1] crossing_accepted
  // configuration writes
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i
);

  acpd_cfg_t cfg;

  logic in_valid_q, in_valid_d;
  logic in_level_q, in_level_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] out_data_q, out_data_d;
  logic advance, step;
  logic triac_on, crossing;

  assign cfg_ready_o = 1'b1;

  acpd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // result register free or draining this cycle
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = advance || !in_valid_q;

  acpd_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .level_i    (in_level_q),
    .cfg_i      (cfg),
    .triac_on_o (triac_on),
    .crossing_o (crossing)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    in_level_d  = in_level_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      in_level_d = s_axis_tdata[0];
    end
    if (advance) begin
      out_valid_d = in_valid_q;
      if (step) begin
        out_data_d = {crossing, triac_on};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload only
  always_ff @(posedge clk_i) begin
    in_level_q <= in_level_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

endmodule

`default_nettype wire
